// File: src/sblp_pkg.sv
// Package for the sector buffer LRU pool: sizes, command and status codes, queue types.
`default_nettype none
package sblp_pkg;
	localparam int ENTRIES = 16;
	localparam int IW = $clog2(ENTRIES);
	localparam int LW = IW + 1;
	localparam logic [LW-1:0] LINK_NONE = LW'(ENTRIES);

	localparam logic [2:0] CMD_ALLOC = 3'd0;
	localparam logic [2:0] CMD_ALLOC_WORK = 3'd1;
	localparam logic [2:0] CMD_RELEASE = 3'd2;
	localparam logic [2:0] CMD_SET = 3'd3;
	localparam logic [2:0] CMD_WALK = 3'd4;

	localparam logic [1:0] ST_OK = 2'd0;
	localparam logic [1:0] ST_EMPTY = 2'd1;
	localparam logic [1:0] ST_EXISTED = 2'd2;

	localparam logic [1:0] ENT_FREE = 2'd0;
	localparam logic [1:0] ENT_WORK = 2'd1;

	typedef struct packed {
		logic [2:0] cmd;
		logic [31:0] sector;
		logic [3:0] buf_index;
		logic [1:0] new_state;
	} item_t;

	typedef enum logic [1:0] {
		BK_IDLE,
		BK_EXEC,
		BK_WALK
	} bk_state_t;
endpackage
`default_nettype wire

// File: src/sblp_front.sv
// Front end: input beat capture and a two-entry command queue.
`default_nettype none
module sblp_front (
	input wire logic clk,
	input wire logic arst_n,
	input wire logic in_valid,
	output logic in_stall,
	input wire sblp_pkg::item_t in_item,
	output logic q_valid,
	output sblp_pkg::item_t q_item,
	input wire logic q_pop
);
	import sblp_pkg::*;

	item_t slot_q [2];
	logic rd_q, wr_q;
	logic [1:0] cnt_q;
	logic push;

	assign in_stall = (cnt_q == 2'd2);
	assign push = in_valid && !in_stall;
	assign q_valid = (cnt_q != 2'd0);
	assign q_item = slot_q[rd_q];

	// queue pointers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rd_q <= 1'b0;
			wr_q <= 1'b0;
			cnt_q <= 2'd0;
		end else begin
			if (push) wr_q <= !wr_q;
			if (q_pop) rd_q <= !rd_q;
			cnt_q <= cnt_q + 2'(push) - 2'(q_pop);
		end
	end

	// payload
	always_ff @(posedge clk) begin
		if (push) slot_q[wr_q] <= in_item;
	end
endmodule
`default_nettype wire

// File: src/sblp_back.sv
// Back end: entry store, linked LRU list and command execution.
`default_nettype none
module sblp_back (
	input wire logic clk,
	input wire logic arst_n,
	input wire logic q_valid,
	input wire sblp_pkg::item_t q_item,
	output logic q_pop,
	output logic out_valid,
	input wire logic out_stall,
	output logic [1:0] status,
	output logic [3:0] entry_index,
	output logic [31:0] entry_sector,
	output logic [1:0] entry_state,
	output logic last
);
	import sblp_pkg::*;

	logic [31:0] tag_q [ENTRIES];
	logic [1:0] st_q [ENTRIES];
	logic [ENTRIES-1:0] listed_q;
	logic [LW-1:0] nxt_q [ENTRIES];
	logic [LW-1:0] prv_q [ENTRIES];
	logic [LW-1:0] head_q, tail_q, walk_q;
	bk_state_t state_q, state_d;
	item_t cur_q;

	// output register can take a new beat
	logic out_free;
	assign out_free = !out_valid || !out_stall;

	// match vector for search allocate and clash check
	logic [ENTRIES-1:0] amatch, clash_v;
	logic [IW-1:0] ridx;
	assign ridx = cur_q.buf_index[IW-1:0];
	always_comb begin
		for (int i = 0; i < ENTRIES; i++) begin
			amatch[i] = listed_q[i] &&
				(st_q[i] == ENT_FREE || tag_q[i] == cur_q.sector);
			clash_v[i] = listed_q[i] && st_q[i] != ENT_FREE &&
				tag_q[i] == tag_q[ridx];
		end
	end

	// first match from head: pick match whose predecessor chain holds no match;
	// a match e is first if no matching entry lies ahead, i.e. prev chain clear.
	// Equivalent: the unique match m whose every earlier listed entry misses.
	// Compute with "ahead" masks: earlier(e) = entries reached from head before e.
	logic [ENTRIES-1:0] ahead_q [ENTRIES];
	logic [LW-1:0] first;
	always_comb begin
		first = LINK_NONE;
		for (int i = 0; i < ENTRIES; i++)
			if (amatch[i] && (ahead_q[i] & amatch) == '0) first = LW'(i);
	end

	logic in_range;
	assign in_range = (ENTRIES == 16) || (32'(cur_q.buf_index) < ENTRIES);

	// execution outcome
	logic [1:0] r_st;
	logic [LW-1:0] r_e, take;
	logic r_show, do_unlink, do_push, do_set;
	always_comb begin
		r_st = ST_OK; r_e = '0; r_show = 1'b0;
		do_unlink = 1'b0; do_push = 1'b0; do_set = 1'b0;
		take = (cur_q.cmd == CMD_ALLOC && first != LINK_NONE) ? first : tail_q;
		unique case (cur_q.cmd)
			CMD_ALLOC, CMD_ALLOC_WORK: begin
				if (head_q == LINK_NONE || take == LINK_NONE) r_st = ST_EMPTY;
				else begin
					r_e = take; r_show = 1'b1; do_unlink = 1'b1;
				end
			end
			CMD_RELEASE: begin
				if (in_range) begin
					r_e = LW'(ridx); r_show = 1'b1;
					if (listed_q[ridx] || clash_v != '0) r_st = ST_EXISTED;
					else do_push = 1'b1;
				end
			end
			CMD_SET: begin
				if (in_range) begin
					r_e = LW'(ridx); r_show = 1'b1; do_set = 1'b1;
				end
			end
			default: ;
		endcase
	end

	// sequencer
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			BK_IDLE: if (q_valid) state_d = (q_item.cmd == CMD_WALK) ? BK_WALK : BK_EXEC;
			BK_EXEC: if (out_free) state_d = BK_IDLE;
			BK_WALK: if (out_free && (walk_q == LINK_NONE ||
				nxt_q[walk_q[IW-1:0]] == LINK_NONE)) state_d = BK_IDLE;
			default: state_d = BK_IDLE;
		endcase
	end
	assign q_pop = (state_q == BK_IDLE) && q_valid;

	logic fire_exec, fire_walk;
	assign fire_exec = (state_q == BK_EXEC) && out_free;
	assign fire_walk = (state_q == BK_WALK) && out_free;

	// control registers and list
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= BK_IDLE;
			out_valid <= 1'b0;
			listed_q <= '1;
			head_q <= LW'(ENTRIES - 1);
			tail_q <= '0;
			walk_q <= '0;
			for (int i = 0; i < ENTRIES; i++) begin
				tag_q[i] <= '0;
				st_q[i] <= ENT_FREE;
				nxt_q[i] <= (i == 0) ? LINK_NONE : LW'(i - 1);
				prv_q[i] <= (i + 1 < ENTRIES) ? LW'(i + 1) : LINK_NONE;
				for (int j = 0; j < ENTRIES; j++) ahead_q[i][j] <= (j > i);
			end
		end else begin
			state_q <= state_d;
			out_valid <= fire_exec || fire_walk || (out_valid && out_stall);
			if (q_pop) walk_q <= head_q;
			if (fire_walk) begin
				if (walk_q != LINK_NONE) walk_q <= nxt_q[walk_q[IW-1:0]];
			end
			if (fire_exec) begin
				if (do_set) begin
					tag_q[ridx] <= cur_q.sector;
					st_q[ridx] <= cur_q.new_state;
				end
				if (do_unlink) begin : unl
					logic [IW-1:0] e;
					logic [LW-1:0] p, n;
					e = r_e[IW-1:0];
					p = prv_q[e]; n = nxt_q[e];
					if (p != LINK_NONE) nxt_q[p[IW-1:0]] <= n;
					if (n != LINK_NONE) prv_q[n[IW-1:0]] <= p;
					if (head_q == r_e) head_q <= n;
					if (tail_q == r_e) tail_q <= p;
					nxt_q[e] <= LINK_NONE;
					prv_q[e] <= LINK_NONE;
					listed_q[e] <= 1'b0;
					// row of an unlisted entry is cleared when it is pushed again
					for (int i = 0; i < ENTRIES; i++) ahead_q[i][e] <= 1'b0;
				end
				if (do_push) begin
					nxt_q[ridx] <= head_q;
					prv_q[ridx] <= LINK_NONE;
					if (head_q == LINK_NONE) tail_q <= LW'(ridx);
					else prv_q[head_q[IW-1:0]] <= LW'(ridx);
					head_q <= LW'(ridx);
					listed_q[ridx] <= 1'b1;
					ahead_q[ridx] <= '0;
					for (int i = 0; i < ENTRIES; i++)
						if (listed_q[i]) ahead_q[i][ridx] <= 1'b1;
				end
			end
		end
	end

	// command and result payload
	always_ff @(posedge clk) begin
		if (q_pop) cur_q <= q_item;
		if (fire_exec) begin
			status <= r_st;
			entry_index <= r_show ? 4'(r_e[IW-1:0]) : 4'd0;
			// set entry reports the values it writes
			entry_sector <= !r_show ? 32'd0 :
				do_set ? cur_q.sector : tag_q[r_e[IW-1:0]];
			entry_state <= !r_show ? 2'd0 :
				do_set ? cur_q.new_state : st_q[r_e[IW-1:0]];
			last <= 1'b1;
		end
		if (fire_walk) begin
			if (walk_q == LINK_NONE) begin
				status <= ST_EMPTY; entry_index <= '0; entry_sector <= '0;
				entry_state <= '0; last <= 1'b1;
			end else begin
				status <= ST_OK;
				entry_index <= 4'(walk_q[IW-1:0]);
				entry_sector <= tag_q[walk_q[IW-1:0]];
				entry_state <= st_q[walk_q[IW-1:0]];
				last <= (nxt_q[walk_q[IW-1:0]] == LINK_NONE);
			end
		end
	end
endmodule
`default_nettype wire

// File: src/sector_buffer_lru_pool.sv
// Top level of the sector buffer LRU pool: front queue plus list engine.
// channel | dir | handshake          | payload
// in      | in  | in_valid/in_stall  | cmd sector buf_index new_state
// out     | out | out_valid/out_stall| status entry_index entry_sector entry_state last
// A command's result beat is presented once the back-end sequencer has popped it from the
// queue and executed it into the output register; the back end takes no new command until
// that beat is registered. A walk gives one beat per cycle per listed entry unless stalled.
// Reset is asynchronous and restores the full free list at once.
// The two-entry queue keeps taking beats while the output is stalled, until it is full.
`default_nettype none
module sector_buffer_lru_pool (
	input wire logic clk,
	input wire logic arst_n,
	input wire logic in_valid,
	output logic in_stall,
	input wire logic [2:0] cmd,
	input wire logic [31:0] sector,
	input wire logic [3:0] buf_index,
	input wire logic [1:0] new_state,
	output logic out_valid,
	input wire logic out_stall,
	output logic [1:0] status,
	output logic [3:0] entry_index,
	output logic [31:0] entry_sector,
	output logic [1:0] entry_state,
	output logic last
);
	import sblp_pkg::*;

	item_t in_item, q_item;
	logic q_valid, q_pop;
	assign in_item = '{cmd: cmd, sector: sector, buf_index: buf_index, new_state: new_state};

	sblp_front u_front (
		.clk(clk), .arst_n(arst_n), .in_valid(in_valid), .in_stall(in_stall),
		.in_item(in_item), .q_valid(q_valid), .q_item(q_item), .q_pop(q_pop)
	);

	sblp_back u_back (
		.clk(clk), .arst_n(arst_n), .q_valid(q_valid), .q_item(q_item), .q_pop(q_pop),
		.out_valid(out_valid), .out_stall(out_stall), .status(status),
		.entry_index(entry_index), .entry_sector(entry_sector),
		.entry_state(entry_state), .last(last)
	);

`ifndef SYNTH
	// a pop needs a queued beat
	a_pop: assert property (@(posedge clk) disable iff (!arst_n) q_pop |-> q_valid)
		else $error("pop from empty queue");
	// status codes stay in range
	a_st: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (status != 2'd3)) else $error("bad status");
	// an empty report is always final
	a_empty: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && status == ST_EMPTY) |-> last) else $error("empty not last");
`endif
endmodule
`default_nettype wire

// File: verif/sector_buffer_lru_pool_tb.sv
// Self-checking testbench for the sector buffer LRU pool: list model, directed and random beats.
`default_nettype none
module sector_buffer_lru_pool_tb;
	timeunit 1ns;
	timeprecision 1ps;
	import sblp_pkg::*;

	localparam int LIMIT = 400000;

	typedef struct packed {
		logic [1:0] status;
		logic [3:0] entry_index;
		logic [31:0] entry_sector;
		logic [1:0] entry_state;
		logic last;
	} beat_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic in_valid = 1'b0;
	logic in_stall;
	logic [2:0] cmd = '0;
	logic [31:0] sector = '0;
	logic [3:0] buf_index = '0;
	logic [1:0] new_state = '0;
	logic out_valid;
	logic out_stall = 1'b0;
	logic [1:0] status;
	logic [3:0] entry_index;
	logic [31:0] entry_sector;
	logic [1:0] entry_state;
	logic last;

	sector_buffer_lru_pool DUT (.*);

	always #6 clk = ~clk;

	// pool model: tags, states, MRU list links
	logic [31:0] m_tag [ENTRIES];
	logic [1:0] m_state [ENTRIES];
	bit m_listed [ENTRIES];
	int m_next [ENTRIES];
	int m_prev [ENTRIES];
	int m_head, m_tail;

	beat_t pending_beats [$];
	int errors = 0;
	int cycles = 0;
	int beats_seen = 0;
	int items_sent = 0;
	int gap_max = 3;
	bit stall_on = 1'b1;

	function automatic beat_t mk_beat(logic [1:0] st, int e, bit show);
		beat_t b;
		b = '0;
		b.status = st;
		if (show) begin
			b.entry_index = e[3:0];
			b.entry_sector = m_tag[e];
			b.entry_state = m_state[e];
		end
		return b;
	endfunction

	function automatic void pool_reset();
		for (int i = 0; i < ENTRIES; i++) begin
			m_tag[i] = '0;
			m_state[i] = ENT_FREE;
			m_listed[i] = 1'b1;
			m_next[i] = (i == 0) ? ENTRIES : i - 1;
			m_prev[i] = (i + 1 < ENTRIES) ? i + 1 : ENTRIES;
		end
		m_head = ENTRIES - 1;
		m_tail = 0;
	endfunction

	function automatic void unlink(int e);
		int p, n;
		p = m_prev[e];
		n = m_next[e];
		if (p < ENTRIES) m_next[p] = n;
		if (n < ENTRIES) m_prev[n] = p;
		if (m_head == e) m_head = n;
		if (m_tail == e) m_tail = p;
		m_next[e] = ENTRIES;
		m_prev[e] = ENTRIES;
		m_listed[e] = 1'b0;
	endfunction

	// predict result beats for one command and update the model
	function automatic void predict_pool(item_t it);
		int e, c, n0;
		bit clash;
		beat_t b;
		n0 = pending_beats.size();
		case (it.cmd)
			CMD_ALLOC, CMD_ALLOC_WORK: begin
				if (m_head >= ENTRIES) pending_beats.push_back(mk_beat(ST_EMPTY, 0, 0));
				else begin
					e = ENTRIES;
					if (it.cmd == CMD_ALLOC) begin
						c = m_head;
						for (int s = 0; s < ENTRIES && c < ENTRIES; s++) begin
							if (m_state[c] == ENT_FREE || m_tag[c] == it.sector) begin
								e = c;
								break;
							end
							c = m_next[c];
						end
					end
					if (e >= ENTRIES) e = m_tail;
					unlink(e);
					pending_beats.push_back(mk_beat(ST_OK, e, 1));
				end
			end
			CMD_RELEASE: begin
				e = it.buf_index;
				clash = m_listed[e];
				c = m_head;
				for (int s = 0; !clash && s < ENTRIES && c < ENTRIES; s++) begin
					if (m_tag[c] == m_tag[e] && m_state[c] != ENT_FREE) clash = 1'b1;
					c = m_next[c];
				end
				if (!clash) begin
					m_next[e] = m_head;
					m_prev[e] = ENTRIES;
					if (m_head >= ENTRIES) m_tail = e;
					else m_prev[m_head] = e;
					m_head = e;
					m_listed[e] = 1'b1;
				end
				pending_beats.push_back(mk_beat(clash ? ST_EXISTED : ST_OK, e, 1));
			end
			CMD_SET: begin
				e = it.buf_index;
				m_state[e] = it.new_state;
				m_tag[e] = it.sector;
				pending_beats.push_back(mk_beat(ST_OK, e, 1));
			end
			CMD_WALK: begin
				c = m_head;
				for (int s = 0; s < ENTRIES && c < ENTRIES; s++) begin
					pending_beats.push_back(mk_beat(ST_OK, c, 1));
					c = m_next[c];
				end
				if (pending_beats.size() == n0)
					pending_beats.push_back(mk_beat(ST_EMPTY, 0, 0));
			end
			default: pending_beats.push_back(mk_beat(ST_OK, 0, 0));
		endcase
		b = pending_beats[$];
		b.last = 1'b1;
		pending_beats[$] = b;
	endfunction

	// send one beat with a random pre-gap; valid stays high across back-to-back beats
	task automatic send_cmd(logic [2:0] c, logic [31:0] s, logic [3:0] idx, logic [1:0] st);
		item_t it;
		int g;
		g = (gap_max == 0) ? 0 : (($urandom_range(0, 3) == 0) ? $urandom_range(1, gap_max) : 0);
		if (g > 0) begin
			in_valid <= 1'b0;
			repeat (g) @(posedge clk);
		end
		in_valid <= 1'b1;
		cmd <= c;
		sector <= s;
		buf_index <= idx;
		new_state <= st;
		it = '{cmd: c, sector: s, buf_index: idx, new_state: st};
		@(posedge clk);
		while (in_stall) @(posedge clk);
		predict_pool(it);
		items_sent++;
	endtask

	task automatic drain();
		in_valid <= 1'b0;
		while (pending_beats.size() != 0) @(posedge clk);
		repeat (8) @(posedge clk);
	endtask

	// output checker
	always @(posedge clk) begin
		beat_t got, exp_b;
		if (arst_n && out_valid && !out_stall) begin
			got = '{status, entry_index, entry_sector, entry_state, last};
			beats_seen++;
			if (pending_beats.size() == 0) begin
				$error("unexpected result beat %p", got);
				errors++;
			end else begin
				exp_b = pending_beats.pop_front();
				if (got.status !== exp_b.status) begin
					$error("status exp %0d got %0d", exp_b.status, got.status); errors++;
				end
				if (got.entry_index !== exp_b.entry_index) begin
					$error("entry_index exp %0d got %0d", exp_b.entry_index,
						got.entry_index); errors++;
				end
				if (got.entry_sector !== exp_b.entry_sector) begin
					$error("entry_sector exp %h got %h", exp_b.entry_sector,
						got.entry_sector); errors++;
				end
				if (got.entry_state !== exp_b.entry_state) begin
					$error("entry_state exp %0d got %0d", exp_b.entry_state,
						got.entry_state); errors++;
				end
				if (got.last !== exp_b.last) begin
					$error("last exp %0d got %0d", exp_b.last, got.last); errors++;
				end
			end
		end
	end

	// receiver stall pattern: bursty, with quiet stretches
	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles % 500 == 0) stall_on <= $urandom_range(0, 2) != 0;
		out_stall <= stall_on ? ($urandom_range(0, 3) == 0) : 1'b0;
	end

	// timeout
	always @(posedge clk) begin
		if (cycles > LIMIT) begin
			$display("sector_buffer_lru_pool_tb: done, errors");
			$finish;
		end
	end

	task automatic test_reset_walk();
		send_cmd(CMD_WALK, '0, '0, '0);
	endtask

	// allocate everything, then hit the empty list cases
	task automatic test_empty_list();
		for (int i = 0; i < ENTRIES; i++)
			send_cmd(i % 2 ? CMD_ALLOC_WORK : CMD_ALLOC, 32'hFFFF_FFFF, '0, '0);
		send_cmd(CMD_ALLOC, 32'h0, '0, '0);
		send_cmd(CMD_ALLOC_WORK, 32'h0, '0, '0);
		send_cmd(CMD_WALK, '0, '0, '0);
	endtask

	// set tags, release, duplicate-sector refusal, unknown commands
	task automatic test_release_set();
		send_cmd(CMD_SET, 32'hFFFF_FFFF, 4'd15, 2'd3);
		send_cmd(CMD_SET, 32'hFFFF_FFFF, 4'd0, ENT_WORK);
		send_cmd(CMD_RELEASE, '0, 4'd15, '0);
		send_cmd(CMD_RELEASE, '0, 4'd0, '0);
		send_cmd(CMD_RELEASE, '0, 4'd15, '0);
		send_cmd(CMD_SET, 32'h1234_5678, 4'd5, ENT_FREE);
		send_cmd(CMD_RELEASE, '0, 4'd5, '0);
		send_cmd(3'd5, 32'hA5A5_A5A5, 4'd3, 2'd2);
		send_cmd(3'd6, '0, '0, '0);
		send_cmd(3'd7, '0, 4'd15, 2'd3);
		send_cmd(CMD_ALLOC, 32'hFFFF_FFFF, '0, '0);
		send_cmd(CMD_WALK, '0, '0, '0);
	endtask

	// random traffic on a small set of sectors so hits and clashes occur
	task automatic test_random(int n);
		logic [2:0] c;
		logic [31:0] s;
		int r;
		for (int i = 0; i < n; i++) begin
			if (i % 40 == 0) gap_max = $urandom_range(0, 6);
			r = $urandom_range(0, 99);
			c = r < 25 ? CMD_ALLOC : r < 35 ? CMD_ALLOC_WORK : r < 65 ? CMD_RELEASE :
				r < 88 ? CMD_SET : r < 96 ? CMD_WALK : 3'($urandom_range(5, 7));
			s = ($urandom_range(0, 4) == 0) ? $urandom() : 32'($urandom_range(0, 5));
			send_cmd(c, s, 4'($urandom_range(0, 15)), 2'($urandom_range(0, 3)));
			if (i == n / 2) drain();
		end
	endtask

	initial begin
		pool_reset();
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_reset_walk();
		test_empty_list();
		test_release_set();
		drain();
		test_random(140);
		drain();
		$display("covered %0d commands, %0d result beats: allocate, work, release, set, walk",
			items_sent, beats_seen);
		$display("including empty list, refused release and unknown command cases");
		if (errors == 0) $display("sector_buffer_lru_pool_tb: done, clean");
		else $display("sector_buffer_lru_pool_tb: done, errors");
		$finish;
	end
endmodule
`default_nettype wire
